// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nsc_pkg.sv -----
// Package with the types, codes and decode functions of the NMEA sentence checker.
package nsc_pkg;

    localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
    localparam logic [7:0] CHAR_STAR      = 8'h2A;
    localparam logic [7:0] HEX_DIGIT_OFS  = 8'h30;
    localparam logic [7:0] HEX_UPPER_OFS  = 8'h37;
    localparam logic [7:0] HEX_LOWER_OFS  = 8'h57;
    localparam logic [7:0] ADDR_LEN       = 8'd5;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd82;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BAD_HEX  = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_GLL   = 3'd2;
    localparam logic [2:0] KIND_RMC   = 3'd3;
    localparam logic [2:0] KIND_GSA   = 3'd4;

    // Address patterns, one row per sentence kind in code order.
    localparam logic [7:0] ADDR_TABLE [4][5] = '{
        '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41},
        '{8'h47, 8'h4E, 8'h47, 8'h4C, 8'h4C},
        '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},
        '{8'h47, 8'h4E, 8'h47, 8'h53, 8'h41}
    };

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] kind;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - HEX_DIGIT_OFS;
            h.ok = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - HEX_UPPER_OFS;
            h.ok = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - HEX_LOWER_OFS;
            h.ok = 1'b1;
        end
        h.val = d[3:0];
        return h;
    endfunction

    // A kind is known only when exactly one pattern survived the address.
    function automatic logic [2:0] kind_of(input logic [3:0] cand);
        logic [2:0] k;
        case (cand)
            4'b0001: k = KIND_GGA;
            4'b0010: k = KIND_GLL;
            4'b0100: k = KIND_RMC;
            4'b1000: k = KIND_GSA;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/nsc_in_reg.sv -----
// Input register of the NMEA sentence checker.
module nsc_in_reg
    import nsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_advance,
    input  logic [7:0] i_data_byte,
    output logic     o_stall,
    output t_in_word o_word
);

    logic       r_vld;
    logic [7:0] r_data;
    logic       accept;

    assign o_stall = r_vld && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data_byte;
        end
    end

    assign o_word.vld  = r_vld;
    assign o_word.data = r_data;

endmodule

// ----- rtl/nsc_core.sv -----
// Sentence state and combinational step logic of the NMEA sentence checker.
module nsc_core
    import nsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  t_in_word i_word,
    input  logic     i_advance,
    output logic     o_emit,
    output t_result  o_result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [3:0] r_hi, n_hi;
    logic [7:0] r_cnt, n_cnt;
    logic [3:0] r_cand, n_cand;
    logic       r_herr, n_herr;
    logic [7:0] r_max_len;

    logic       consume;
    logic [7:0] c;
    t_hex       hx;
    logic [7:0] rs;
    logic       herr_all;

    assign consume = i_word.vld && i_advance;
    assign c       = i_word.data;
    assign hx      = hex_decode(c);
    assign rs      = {r_hi, hx.val};
    assign herr_all = r_herr || !hx.ok;

    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_hi     = r_hi;
        n_cnt    = r_cnt;
        n_cand   = r_cand;
        n_herr   = r_herr;
        o_emit   = 1'b0;
        o_result = '0;
        if (consume) begin
            if (c == CHAR_DOLLAR) begin
                n_phase = PH_BODY;
                n_xor   = '0;
                n_hi    = '0;
                n_cnt   = '0;
                n_cand  = 4'hF;
                n_herr  = 1'b0;
            end else begin
                case (r_phase)
                    PH_BODY: begin
                        if (c == CHAR_STAR) begin
                            n_phase = PH_HEX1;
                        end else if (r_cnt >= r_max_len) begin
                            o_emit                = 1'b1;
                            o_result.status       = ST_TOO_LONG;
                            o_result.kind         = KIND_OTHER;
                            o_result.computed_sum = r_xor;
                            o_result.received_sum = '0;
                            n_phase               = PH_IDLE;
                        end else begin
                            if (r_cnt < ADDR_LEN) begin
                                for (int k = 0; k < 4; k++) begin
                                    if (ADDR_TABLE[k][r_cnt[2:0]] != c) begin
                                        n_cand[k] = 1'b0;
                                    end
                                end
                            end
                            n_xor = r_xor ^ c;
                            n_cnt = r_cnt + 8'd1;
                        end
                    end
                    PH_HEX1: begin
                        if (!hx.ok) begin
                            n_herr = 1'b1;
                        end
                        n_hi    = hx.val;
                        n_phase = PH_HEX2;
                    end
                    PH_HEX2: begin
                        o_emit = 1'b1;
                        if (herr_all) begin
                            o_result.status = ST_BAD_HEX;
                        end else if (rs == r_xor) begin
                            o_result.status = ST_OK;
                        end else begin
                            o_result.status = ST_MISMATCH;
                        end
                        o_result.kind         = (r_cnt < ADDR_LEN) ? KIND_OTHER
                                                                   : kind_of(r_cand);
                        o_result.computed_sum = r_xor;
                        o_result.received_sum = rs;
                        n_herr                = herr_all;
                        n_phase               = PH_IDLE;
                    end
                    PH_IDLE: begin
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_xor     <= '0;
            r_hi      <= '0;
            r_cnt     <= '0;
            r_cand    <= 4'hF;
            r_herr    <= 1'b0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
            r_cand  <= n_cand;
            r_herr  <= n_herr;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/nsc_out_reg.sv -----
// Result register of the NMEA sentence checker.
module nsc_out_reg
    import nsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_stall,
    input  logic    i_emit,
    input  t_result i_result,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_vld;
    t_result r_res;

    // The register can take a new word when it is empty or being drained.
    assign o_advance = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_advance) begin
            r_vld <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_emit) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

endmodule

// ----- rtl/nmea_sentence_checker.sv -----
// Top level of the NMEA 0183 sentence checksum checker.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_data_byte
//   result    out        o_valid / i_stall   o_status, o_sentence_kind,
//                                            o_computed_sum, o_received_sum
//   config    in         i_cfg_we            i_cfg_data (max_length)
//
// One byte is taken per cycle while the input side does not stall; the last byte
// passes the input register, then the step logic into the result register.
// Reset is synchronous and sets max_length to 82 with no sentence under way.
// A stall on the result side holds the pipeline; the input side stalls only
// when a byte is waiting and the result register cannot take a new word.
module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_sentence_kind,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

    t_in_word in_word;
    logic     advance;
    logic     emit;
    t_result  step_res;
    t_result  out_res;

    nsc_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_advance   (advance),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .o_word      (in_word)
    );

    nsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_word     (in_word),
        .i_advance  (advance),
        .o_emit     (emit),
        .o_result   (step_res)
    );

    nsc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stall   (i_stall),
        .i_emit    (emit),
        .i_result  (step_res),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_result  (out_res)
    );

    assign o_status        = out_res.status;
    assign o_sentence_kind = out_res.kind;
    assign o_computed_sum  = out_res.computed_sum;
    assign o_received_sum  = out_res.received_sum;

endmodule

// ----- rtl/nsc_checker.sv -----
// Port-level assertions for the NMEA sentence checker, bound to the top level.
`include "assert_macros.svh"

module nsc_checker
    import nsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic [2:0] o_sentence_kind,
    input logic [7:0] o_computed_sum,
    input logic [7:0] o_received_sum
);

    logic too_long_clean;
    logic ok_sums_equal;
    logic sums_differ;

    assign too_long_clean = !o_valid || o_status != ST_TOO_LONG ||
                            (o_sentence_kind == KIND_OTHER && o_received_sum == 8'd0);
    assign ok_sums_equal  = !o_valid || o_status != ST_OK ||
                            o_computed_sum == o_received_sum;
    assign sums_differ    = !o_valid || o_status != ST_MISMATCH ||
                            o_computed_sum != o_received_sum;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result word dropped")

    `ASSERT_ALWAYS(a_too_long_fields, i_clk, i_rst_n, too_long_clean, "too-long word has a kind")

    `ASSERT_ALWAYS(a_ok_match, i_clk, i_rst_n, ok_sums_equal, "ok status with differing sums")

    `ASSERT_ALWAYS(a_mismatch_differs, i_clk, i_rst_n, sums_differ, "mismatch with equal sums")

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (.*);
